### design/dtip_pkg.sv
// ----------------------------------------------------------------------------
// dtip_pkg
// Shared types and constants for the decimal text to integer parser.
// ----------------------------------------------------------------------------
`default_nettype none

package dtip_pkg;

    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned EXP_W   = 6;

    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_E     = 8'h45;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

    localparam logic [VALUE_W-1:0] MANT_LIMIT = 32'd214748363;
    localparam logic [VALUE_W-1:0] SAT_VALUE  = 32'h7FFF_FFFF;
    localparam logic [VALUE_W-1:0] RECIP_10   = 32'hCCCC_CCCD;

    localparam logic [EXP_W-1:0] EXP_MAX      = 6'd63;
    localparam logic [EXP_W-1:0] EXP_NEG_ZERO = 6'd10;

    typedef struct packed {
        logic consume;
        logic scale;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic scale_done;
    } t_dp_stat;

endpackage

`default_nettype wire

### design/dtip_if.sv
// ----------------------------------------------------------------------------
// dtip_if
// Character and result channels of the decimal text to integer parser.
// ----------------------------------------------------------------------------
`default_nettype none

interface dtip_in_if;
    logic                         valid;
    logic                         ready;
    logic [dtip_pkg::CHAR_W-1:0]  char_code;
    logic                         has_char;
    logic                         last_char;

    modport source (output valid, char_code, has_char, last_char, input ready);
    modport sink   (input valid, char_code, has_char, last_char, output ready);
endinterface

interface dtip_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [dtip_pkg::VALUE_W-1:0] value;
    logic                                saturated;

    modport source (output valid, value, saturated, input ready);
    modport sink   (input valid, value, saturated, output ready);
endinterface

`default_nettype wire

### design/decimal_text_to_int_parser_top.sv
// ----------------------------------------------------------------------------
// decimal_text_to_int_parser_top
// Decimal text to signed 32-bit integer parser with optional E exponent.
// ----------------------------------------------------------------------------
//  channel   dir  handshake         payload
//  i_in      in   valid / ready     char_code[7:0], has_char, last_char
//  o_out     out  valid / ready     value[31:0] signed, saturated
//  cfg       in   i_cfg_we          i_cfg_wdata (exponent enable)
//
//  Characters that do not end a string are taken back to back.
//  After the ending character the datapath scales by the exponent count E,
//  one x10 or div10 step per cycle (1 step for E >= 10 negative), then loads.
//  i_in.ready drops from the ending transfer until the result is loaded.
//  A waiting result stalls only the load; reset is synchronous, active low.
// ----------------------------------------------------------------------------
`default_nettype none

module decimal_text_to_int_parser_top (
    input  wire         i_clk,
    input  wire         i_rst_n,
    dtip_in_if.sink     i_in,
    dtip_out_if.source  o_out,
    input  wire         i_cfg_we,
    input  wire         i_cfg_wdata
);

    dtip_pkg::t_dp_cmd  w_cmd;
    dtip_pkg::t_dp_stat w_stat;

    dtip_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_last   (i_in.last_char),
        .i_out_ready (o_out.ready),
        .i_stat      (w_stat),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (w_cmd)
    );

    dtip_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_char_code (i_in.char_code),
        .i_has_char  (i_in.has_char),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_value     (o_out.value),
        .o_saturated (o_out.saturated)
    );

    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.saturated) |-> (o_out.value == dtip_pkg::SAT_VALUE))
        else $error("saturated result without maximum value");

    a_last_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.last_char) |=> !i_in.ready)
        else $error("input still ready after ending transfer");

    a_load_while_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(!i_in.ready))
        else $error("result loaded while input was open");

    a_no_scale_on_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.scale && w_cmd.consume))
        else $error("scaling step during input transfer");

endmodule

`default_nettype wire

### design/dtip_ctrl.sv
// ----------------------------------------------------------------------------
// dtip_ctrl
// Controller: string parsing, exponent scaling and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module dtip_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    input  wire                 i_in_last,
    input  wire                 i_out_ready,
    input  wire dtip_pkg::t_dp_stat i_stat,
    output logic                o_in_ready,
    output logic                o_out_valid,
    output dtip_pkg::t_dp_cmd   o_cmd
);

    localparam logic [1:0] S_PARSE  = 2'd0;
    localparam logic [1:0] S_SCALE  = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       w_xfer_in;
    logic       w_load;

    assign o_in_ready  = (r_state == S_PARSE);
    assign o_out_valid = r_out_valid;
    assign w_xfer_in   = i_in_valid && o_in_ready;
    assign w_load      = (r_state == S_FINISH) && (!r_out_valid || i_out_ready);

    assign o_cmd.consume  = w_xfer_in;
    assign o_cmd.scale    = (r_state == S_SCALE) && !i_stat.scale_done;
    assign o_cmd.load_out = w_load;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_PARSE: begin
                if (w_xfer_in && i_in_last) begin
                    n_state = S_SCALE;
                end
            end
            S_SCALE: begin
                if (i_stat.scale_done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (w_load) begin
                    n_state = S_PARSE;
                end
            end
            default: begin
                n_state = S_PARSE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_PARSE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

### design/dtip_datapath.sv
// ----------------------------------------------------------------------------
// dtip_datapath
// Parse registers, shared x10 / div10 scaling step and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dtip_datapath (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_we,
    input  wire                                 i_cfg_wdata,
    input  wire  [dtip_pkg::CHAR_W-1:0]         i_char_code,
    input  wire                                 i_has_char,
    input  wire dtip_pkg::t_dp_cmd              i_cmd,
    output dtip_pkg::t_dp_stat                  o_stat,
    output logic signed [dtip_pkg::VALUE_W-1:0] o_value,
    output logic                                o_saturated
);

    localparam logic [2:0] PH_SIGN  = 3'd0;
    localparam logic [2:0] PH_MANT  = 3'd1;
    localparam logic [2:0] PH_ESIGN = 3'd2;
    localparam logic [2:0] PH_EDIG  = 3'd3;
    localparam logic [2:0] PH_DONE  = 3'd4;

    logic                           r_exp_en;
    logic [2:0]                     r_phase, n_phase;
    logic                           r_neg, n_neg;
    logic [dtip_pkg::VALUE_W-1:0]   r_mant, n_mant;
    logic                           r_ovf, n_ovf;
    logic                           r_eneg, n_eneg;
    logic [dtip_pkg::EXP_W-1:0]     r_exp, n_exp;
    logic signed [dtip_pkg::VALUE_W-1:0] r_value;
    logic                           r_sat;

    logic                           w_digit;
    logic [3:0]                     w_dval;
    logic [dtip_pkg::CHAR_W-1:0]    w_dsub;
    logic [9:0]                     w_exp_next;
    logic [dtip_pkg::VALUE_W-1:0]   w_mant_next;
    logic [dtip_pkg::VALUE_W-1:0]   w_mul10;
    logic [2*dtip_pkg::VALUE_W-1:0] w_prod;
    logic [dtip_pkg::VALUE_W-1:0]   w_div10;
    logic [dtip_pkg::VALUE_W-1:0]   w_final;

    assign w_digit = (i_char_code >= dtip_pkg::CH_ZERO) && (i_char_code <= dtip_pkg::CH_NINE);
    assign w_dsub  = i_char_code - dtip_pkg::CH_ZERO;
    assign w_dval  = w_dsub[3:0];

    assign w_exp_next  = {1'b0, r_exp, 3'b000} + {3'b000, r_exp, 1'b0} + {6'b0, w_dval};
    assign w_mul10     = {r_mant[28:0], 3'b000} + {r_mant[30:0], 1'b0};
    assign w_mant_next = w_mul10 + {28'b0, w_dval};

    // floor(x / 10) = (x * ceil(2^35 / 10)) >> 35, exact over 32 bits
    assign w_prod  = r_mant * dtip_pkg::RECIP_10;
    assign w_div10 = {3'b000, w_prod[63:35]};

    assign w_final = r_neg ? (32'd0 - r_mant) : r_mant;

    assign o_stat.scale_done = r_ovf || (r_exp == '0);
    assign o_value           = r_value;
    assign o_saturated       = r_sat;

    always_comb begin
        logic [2:0] ph;
        logic       handled;
        n_phase = r_phase;
        n_neg   = r_neg;
        n_mant  = r_mant;
        n_ovf   = r_ovf;
        n_eneg  = r_eneg;
        n_exp   = r_exp;
        ph      = r_phase;
        handled = 1'b0;
        if (i_cmd.load_out) begin
            n_phase = PH_SIGN;
            n_neg   = 1'b0;
            n_mant  = '0;
            n_ovf   = 1'b0;
            n_eneg  = 1'b0;
            n_exp   = '0;
        end else if (i_cmd.scale) begin
            if (r_eneg) begin
                if (r_exp >= dtip_pkg::EXP_NEG_ZERO) begin
                    n_mant = '0;
                    n_exp  = '0;
                end else begin
                    n_mant = w_div10;
                    n_exp  = r_exp - 6'd1;
                end
            end else begin
                n_mant = w_mul10;
                n_exp  = r_exp - 6'd1;
            end
        end else if (i_cmd.consume && i_has_char && (r_phase < PH_DONE)) begin
            if (ph == PH_SIGN) begin
                if (i_char_code == dtip_pkg::CH_PLUS) begin
                    handled = 1'b1;
                end else if (i_char_code == dtip_pkg::CH_MINUS) begin
                    n_neg   = ~r_neg;
                    handled = 1'b1;
                end else begin
                    ph = PH_MANT;
                end
            end
            if (!handled && ph == PH_MANT) begin
                handled = 1'b1;
                if (w_digit) begin
                    if (r_mant > dtip_pkg::MANT_LIMIT) begin
                        n_ovf = 1'b1;
                        ph    = PH_DONE;
                    end else begin
                        n_mant = w_mant_next;
                    end
                end else if (i_char_code == dtip_pkg::CH_E && r_exp_en) begin
                    ph = PH_ESIGN;
                end else begin
                    ph = PH_DONE;
                end
            end
            if (!handled && ph == PH_ESIGN) begin
                ph = PH_EDIG;
                if (i_char_code == dtip_pkg::CH_MINUS) begin
                    n_eneg  = 1'b1;
                    handled = 1'b1;
                end else if (i_char_code == dtip_pkg::CH_PLUS) begin
                    handled = 1'b1;
                end
            end
            if (!handled && ph == PH_EDIG) begin
                if (w_digit) begin
                    n_exp = (w_exp_next > {4'b0, dtip_pkg::EXP_MAX}) ? dtip_pkg::EXP_MAX
                                                                     : w_exp_next[5:0];
                end else begin
                    ph = PH_DONE;
                end
            end
            n_phase = ph;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_en <= 1'b0;
            r_phase  <= PH_SIGN;
            r_neg    <= 1'b0;
            r_mant   <= '0;
            r_ovf    <= 1'b0;
            r_eneg   <= 1'b0;
            r_exp    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_exp_en <= i_cfg_wdata;
            end
            r_phase <= n_phase;
            r_neg   <= n_neg;
            r_mant  <= n_mant;
            r_ovf   <= n_ovf;
            r_eneg  <= n_eneg;
            r_exp   <= n_exp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_value <= r_ovf ? dtip_pkg::SAT_VALUE : w_final;
            r_sat   <= r_ovf;
        end
    end

endmodule

`default_nettype wire
